### rtl/url_percent_decoder_core_macros.svh
// Assertion macros for the checker file.
`ifndef URL_PERCENT_DECODER_CORE_MACROS_SVH
`define URL_PERCENT_DECODER_CORE_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define UPD_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define UPD_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

// Check a consequence after its cause.
`define UPD_ASSERT_TWO(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

### rtl/upd_pkg.sv
`default_nettype none
package upd_pkg;

  // Characters the decoder acts on
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  // 'A' - 10 and 'a' - 'A'
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;
  localparam logic [7:0] CASE_OFS      = 8'd32;

  localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

  // Candidate data bytes per input word, and slots per queue entry
  localparam int CAND    = 3;
  localparam int SLOTS   = 4;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_PCT   = 2'd1,
    MODE_DIGIT = 2'd2,
    MODE_STOP  = 2'd3
  } upd_mode_t;

  // Up to four output words produced by one input word
  typedef struct packed {
    logic [SLOTS-1:0][7:0] bytes;
    logic [2:0]            n;
    logic                  term;
  } upd_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } upd_qstat_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) || ((c >= CH_UA) && (c <= CH_UF)) ||
           ((c >= CH_LA) && (c <= CH_LF));
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] u;
    logic [7:0] d;
    u = (c >= CH_LA) ? (c - CASE_OFS) : c;
    d = (u >= CH_UA) ? (u - HEX_ALPHA_OFS) : (u - CH_ZERO);
    return d[3:0];
  endfunction

  // Mode after a byte is taken as plain text
  function automatic upd_mode_t plain_mode(input logic [7:0] c);
    upd_mode_t m;
    if (c == CH_NUL) begin
      m = MODE_STOP;
    end else if (c == CH_PCT) begin
      m = MODE_PCT;
    end else begin
      m = MODE_PLAIN;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### rtl/upd_in_if.sv
`default_nettype none
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source(output valid, output in_byte, output in_last, input ready);
  modport sink(input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

### rtl/upd_out_if.sv
`default_nettype none
interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source(output valid, output out_byte, output out_last, input ready);
  modport sink(input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

### rtl/upd_front.sv
`default_nettype none
module upd_front
  import upd_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  upd_in_if.sink           din,
  input  wire logic [15:0] output_limit,
  input  wire upd_qstat_t  qstat,
  output logic             push,
  output upd_entry_t       entry
);

  localparam int LW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  upd_mode_t             mode;
  upd_mode_t             mode_mid;
  upd_mode_t             mode_next;
  logic [7:0]            held_digit;
  logic [7:0]            held_mid;
  logic [7:0]            held_next;
  logic [COUNT_BITS-1:0] emitted_count;
  logic [COUNT_BITS-1:0] count_next;

  logic [7:0]          c;
  logic                last;
  logic                hx;
  logic                accept;
  logic [CAND-1:0][7:0] cand;
  logic [1:0]          k;
  logic [LW-1:0]       cnt_ext;
  logic [LW-1:0]       lim_ext;
  logic [LW-1:0]       cmax_ext;
  logic [LW-1:0]       lim_eff;
  logic [LW-1:0]       room;
  logic [1:0]          room_sat;
  logic [1:0]          keep;

  assign c      = din.in_byte;
  assign last   = din.in_last;
  assign hx     = is_hex(c);
  assign din.ready = !qstat.full;
  assign accept = din.valid && din.ready;

  // Next mode and held digit
  always_comb begin
    mode_mid = mode;
    held_mid = held_digit;
    unique case (mode)
      MODE_PLAIN: mode_mid = plain_mode(c);
      MODE_PCT: begin
        if (hx) begin
          mode_mid = MODE_DIGIT;
          held_mid = c;
        end else begin
          mode_mid = plain_mode(c);
        end
      end
      MODE_DIGIT: begin
        held_mid = CH_NUL;
        mode_mid = hx ? MODE_PLAIN : plain_mode(c);
      end
      MODE_STOP: mode_mid = MODE_STOP;
      default:   mode_mid = MODE_PLAIN;
    endcase
    if (last) begin
      mode_next = MODE_PLAIN;
      held_next = CH_NUL;
    end else begin
      mode_next = mode_mid;
      held_next = held_mid;
    end
  end

  // Collect candidate data bytes in emission order
  always_comb begin
    cand = '0;
    k    = 2'd0;
    if (mode == MODE_PCT && !hx) begin
      cand[k] = CH_PCT;
      k       = k + 2'd1;
    end
    if (mode == MODE_DIGIT) begin
      if (hx) begin
        cand[k] = {hex_value(held_digit), hex_value(c)};
        k       = k + 2'd1;
      end else begin
        cand[k] = CH_PCT;
        k       = k + 2'd1;
        cand[k] = held_digit;
        k       = k + 2'd1;
      end
    end
    if (((mode == MODE_PLAIN) || (mode == MODE_PCT && !hx) || (mode == MODE_DIGIT && !hx)) &&
        (c != CH_NUL) && (c != CH_PCT)) begin
      cand[k] = (c == CH_PLUS) ? CH_SPACE : c;
      k       = k + 2'd1;
    end
    if (last && mode_mid == MODE_PCT) begin
      cand[k] = CH_PCT;
      k       = k + 2'd1;
    end
    if (last && mode_mid == MODE_DIGIT) begin
      cand[k] = CH_PCT;
      k       = k + 2'd1;
      cand[k] = held_mid;
      k       = k + 2'd1;
    end
  end

  // Trim candidates against the limit and the counter ceiling
  always_comb begin
    cnt_ext  = LW'(emitted_count);
    lim_ext  = LW'(output_limit);
    cmax_ext = LW'({COUNT_BITS{1'b1}});
    lim_eff  = (lim_ext < cmax_ext) ? lim_ext : cmax_ext;
    room     = (cnt_ext < lim_eff) ? (lim_eff - cnt_ext) : '0;
    room_sat = (room >= LW'(3)) ? 2'd3 : room[1:0];
    keep     = (k < room_sat) ? k : room_sat;
    count_next = last ? '0 : (emitted_count + COUNT_BITS'(keep));
  end

  // Build the queue entry; the terminator slot is a zero byte
  always_comb begin
    entry.bytes = '0;
    for (int i = 0; i < CAND; i++) begin
      if (2'(i) < keep) begin
        entry.bytes[i] = cand[i];
      end
    end
    entry.n    = {1'b0, keep} + {2'b00, last};
    entry.term = last;
    push       = accept && (entry.n != 3'd0);
  end

  // Advance state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_PLAIN;
      held_digit    <= CH_NUL;
      emitted_count <= '0;
    end else if (accept) begin
      mode          <= mode_next;
      held_digit    <= held_next;
      emitted_count <= count_next;
    end
  end

endmodule
`default_nettype wire

### rtl/upd_queue.sv
`default_nettype none
module upd_queue
  import upd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire upd_entry_t push_entry,
  input  wire logic       pop,
  output upd_entry_t      head,
  output upd_qstat_t      qstat
);

  upd_entry_t      mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            do_push;
  logic            do_pop;

  assign qstat.full  = (count == (Q_AW + 1)'(Q_DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem[rd_ptr];

  // Write the entry store
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (Q_AW + 1)'(do_push) - (Q_AW + 1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

### rtl/upd_back.sv
`default_nettype none
module upd_back
  import upd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire upd_entry_t head,
  input  wire upd_qstat_t qstat,
  output logic            pop,
  upd_out_if.source       dout
);

  upd_entry_t cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       last_slot;
  logic       take;

  assign last_slot     = ({1'b0, idx} == (cur.n - 3'd1));
  assign take          = cur_valid && dout.ready;
  assign pop           = !qstat.empty && (!cur_valid || (take && last_slot));
  assign dout.valid    = cur_valid;
  assign dout.out_byte = cur.bytes[idx];
  assign dout.out_last = cur.term && last_slot;

  // Hold the working entry; load the next one as the last word leaves or while none is held
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (take) begin
      if (last_slot) begin
        cur_valid <= 1'b0;
        idx       <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/url_percent_decoder_core.sv
// Channel  Dir  Payload              Handshake
// din      in   in_byte[8], in_last  valid/ready
// dout     out  out_byte[8], out_last valid/ready
// cfg      in   cfg_data[16]         cfg_we, no ready
//
// An input word is taken every cycle while the four-entry queue has room.
// Each word yields zero to four output words; the output stage sends one a cycle
// while dout is ready, so a word that flushes an escape and ends a message yields up to four.
// The first output of an input word passes through the queue and then the output stage register.
// Synchronous reset clears mode, held digit, count and queue; limit returns to 65535.
// Either side may stall; the queue absorbs up to four words of slack.
`default_nettype none
module url_percent_decoder_core
  import upd_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  upd_in_if.sink           din,
  upd_out_if.source        dout,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] output_limit;
  upd_entry_t  entry;
  upd_entry_t  head;
  upd_qstat_t  qstat;
  logic        push;
  logic        pop;

  // Hold the output limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      output_limit <= cfg_data;
    end
  end

  upd_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .din         (din),
    .output_limit(output_limit),
    .qstat       (qstat),
    .push        (push),
    .entry       (entry)
  );

  upd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(entry),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  upd_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .qstat(qstat),
    .pop  (pop),
    .dout (dout)
  );

endmodule
`default_nettype wire

### rtl/upd_checker.sv
`default_nettype none
`include "url_percent_decoder_core_macros.svh"
module upd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_last,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  // A stalled output word holds
  `UPD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last), "output word changed while stalled")

  // The message terminator is a zero byte
  `UPD_ASSERT_NOW(a_term_zero, clk, rst, out_valid && out_last, out_byte == 8'h00, "terminator byte is not zero")

  // Backpressure on the input only while output holds a word
  `UPD_ASSERT_NOW(a_stall_cause, clk, rst, !in_ready, out_valid, "input stalled with output idle")

  // A message end taken while the output is idle reaches it through the queue and output stage
  `UPD_ASSERT_TWO(a_term_latency, clk, rst, in_valid && in_ready && in_last && !out_valid, out_valid, "message end did not reach output")

endmodule

bind url_percent_decoder_core upd_checker u_upd_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (din.valid),
  .in_ready (din.ready),
  .in_last  (din.in_last),
  .out_valid(dout.valid),
  .out_ready(dout.ready),
  .out_byte (dout.out_byte),
  .out_last (dout.out_last)
);
`default_nettype wire

### sim/upd_stream_checker.sv
`timescale 1ns / 1ps
module upd_stream_checker
  import upd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  upd_in_if           din,
  upd_out_if          dout,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          waiting,
  output int          words_in,
  output int          words_out,
  output int          messages
);

  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  // Keep the log readable when the block is badly broken
  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  out_word_t             decoded_q[$];
  upd_mode_t             mode;
  logic [7:0]            held;
  logic [COUNT_BITS-1:0] data_count;
  logic [15:0]           limit;
  int                    fails;
  int                    n_in;
  int                    n_out;
  int                    n_msg;

  function automatic logic hex_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE], [CH_UA:CH_UF], [CH_LA:CH_LF]};
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CH_LA) begin
      v = c - CH_LA + 8'd10;
    end else if (c >= CH_UA) begin
      v = c - CH_UA + 8'd10;
    end else begin
      v = c - CH_ZERO;
    end
    return v[3:0];
  endfunction

  // Queue one data word unless the message has hit its limit or the counter ceiling
  task automatic emit(input logic [7:0] b);
    if (data_count < limit && data_count != COUNT_MAX) begin
      decoded_q.push_back({b, 1'b0});
      data_count++;
    end
  endtask

  task automatic take_plain(input logic [7:0] c);
    if (c == CH_NUL) begin
      mode = MODE_STOP;
    end else if (c == CH_PCT) begin
      mode = MODE_PCT;
    end else if (c == CH_PLUS) begin
      emit(CH_SPACE);
    end else begin
      emit(c);
    end
  endtask

  // Advance the decoder by one input word and queue what it yields
  task automatic decode_word(input logic [7:0] c, input logic last);
    case (mode)
      MODE_PLAIN: begin
        take_plain(c);
      end
      MODE_PCT: begin
        if (hex_digit(c)) begin
          held = c;
          mode = MODE_DIGIT;
        end else begin
          emit(CH_PCT);
          mode = MODE_PLAIN;
          take_plain(c);
        end
      end
      MODE_DIGIT: begin
        if (hex_digit(c)) begin
          emit({nibble(held), nibble(c)});
        end else begin
          emit(CH_PCT);
          emit(held);
        end
        if (!hex_digit(c)) begin
          held = '0;
          mode = MODE_PLAIN;
          take_plain(c);
        end else begin
          held = '0;
          mode = MODE_PLAIN;
        end
      end
      default: begin
      end
    endcase

    // Flush a pending escape, then close the message
    if (last) begin
      if (mode == MODE_PCT) begin
        emit(CH_PCT);
      end else if (mode == MODE_DIGIT) begin
        emit(CH_PCT);
        emit(held);
      end
      decoded_q.push_back({CH_NUL, 1'b1});
      mode = MODE_PLAIN;
      held = '0;
      data_count = '0;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      decoded_q.delete();
      mode = MODE_PLAIN;
      held = '0;
      data_count = '0;
      limit = LIMIT_RESET;
      fails = 0;
      n_in = 0;
      n_out = 0;
      n_msg = 0;
    end else begin
      // Predict from every accepted input word
      if (din.valid && din.ready) begin
        n_in++;
        if (din.in_last) begin
          n_msg++;
        end
        decode_word(din.in_byte, din.in_last);
      end

      // Compare every accepted output word with the oldest prediction
      if (dout.valid && dout.ready) begin
        n_out++;
        if (decoded_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_CAP) begin
            $display("%0t: unexpected word: expected none, actual byte=%02h last=%0b",
                     $time, dout.out_byte, dout.out_last);
          end
        end else begin
          want = decoded_q.pop_front();
          if (dout.out_byte !== want.data) begin
            fails++;
            if (fails <= REPORT_CAP) begin
              $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                       $time, want.data, dout.out_byte);
            end
          end
          if (dout.out_last !== want.last) begin
            fails++;
            if (fails <= REPORT_CAP) begin
              $display("%0t: out_last mismatch: expected %0b, actual %0b",
                       $time, want.last, dout.out_last);
            end
          end
        end
      end

      // Track the limit register
      if (cfg_we) begin
        limit = cfg_data;
      end
    end

    errors    <= fails;
    waiting   <= decoded_q.size();
    words_in  <= n_in;
    words_out <= n_out;
    messages  <= n_msg;
  end

endmodule

### sim/tb_url_percent_decoder_core.sv
`timescale 1ns / 1ps
module tb_url_percent_decoder_core;
  import upd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 38;
  localparam int IDLE_PCT    = 32;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_data;

  upd_in_if  din();
  upd_out_if dout();

  int         errors;
  int         waiting;
  int         words_in;
  int         words_out;
  int         messages;
  int         cycles;
  int         settings;
  bit         gaps_on;
  bit         stalls_on;
  logic [7:0] msg_bytes[$];

  url_percent_decoder_core uut (
    .clk      (clk),
    .rst      (rst),
    .din      (din),
    .dout     (dout),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  upd_stream_checker chk (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .dout      (dout),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .waiting   (waiting),
    .words_in  (words_in),
    .words_out (words_out),
    .messages  (messages)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the output side at random while stalls are enabled
  always @(posedge clk) begin
    dout.ready <= !rst && (!stalls_on || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [7:0] pick_hex();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) begin
      return CH_ZERO + 8'(v);
    end
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] pick_non_hex();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(1, CH_ZERO - 1));
      1:       return 8'($urandom_range(CH_NINE + 1, CH_UA - 1));
      2:       return 8'($urandom_range(CH_UF + 1, CH_LA - 1));
      default: return 8'($urandom_range(CH_LF + 1, 8'hFF));
    endcase
  endfunction

  // Hold the word until the block takes it; idle before it at random
  task automatic send_word(input logic [7:0] b, input logic last);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        din.valid <= 1'b0;
        @(posedge clk);
      end
    end
    din.valid   <= 1'b1;
    din.in_byte <= b;
    din.in_last <= last;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) begin
      send_word(msg_bytes[i], i == msg_bytes.size() - 1);
    end
  endtask

  // Drop valid and hold until every predicted word is out and the pipe is empty
  task automatic settle();
    din.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limit(input logic [15:0] v);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Build one message: mostly escapes and text, some broken escapes and early ends
  task automatic make_message();
    int tokens;
    int r;
    msg_bytes.delete();
    tokens = $urandom_range(1, 8);
    repeat (tokens) begin
      r = $urandom_range(0, 99);
      if (r < 28) begin
        msg_bytes.push_back(8'($urandom_range(1, 255)));
      end else if (r < 40) begin
        msg_bytes.push_back(CH_PLUS);
      end else if (r < 72) begin
        msg_bytes.push_back(CH_PCT);
        msg_bytes.push_back(pick_hex());
        msg_bytes.push_back(pick_hex());
      end else if (r < 86) begin
        msg_bytes.push_back(CH_PCT);
        if ($urandom_range(0, 1)) begin
          msg_bytes.push_back(pick_hex());
        end
        msg_bytes.push_back($urandom_range(0, 3) == 0 ? CH_PCT : pick_non_hex());
      end else if (r < 92) begin
        msg_bytes.push_back(CH_NUL);
        repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        msg_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    // Leave an escape open at the end now and then
    if ($urandom_range(0, 9) == 0) begin
      msg_bytes.push_back(CH_PCT);
      if ($urandom_range(0, 1)) begin
        msg_bytes.push_back(pick_hex());
      end
    end
  endtask

  task automatic random_phase();
    int sent;
    sent = 0;
    while (sent < PHASE_WORDS) begin
      make_message();
      send_message();
      sent += msg_bytes.size();
    end
  endtask

  initial begin
    din.valid   <= 1'b0;
    din.in_byte <= '0;
    din.in_last <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_data    <= '0;
    rst         <= 1'b1;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    settings  = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Escapes in both cases, decoded zero, plus, raw high bytes, broken escapes,
    // and an escape still open at the last word
    msg_bytes = {CH_PCT, "4", "1", CH_PCT, "f", "F", CH_PCT, "0", "0", CH_PLUS,
                 8'hFF, 8'h80, CH_PCT, "G", CH_PCT, "a", CH_PLUS,
                 CH_PCT, CH_PCT, "3", "z", CH_PCT, "B"};
    send_message();
    // Bytes after a zero are ignored
    msg_bytes = {"x", CH_NUL, "y", "q"};
    send_message();
    // Lone percent as the whole message, then percent followed by zero
    msg_bytes = {CH_PCT};
    send_message();
    msg_bytes = {CH_PCT, CH_NUL};
    send_message();

    // Random messages under the reset limit, then across several limits
    random_phase();
    set_limit(16'd0);
    random_phase();
    set_limit(16'd2);
    random_phase();
    set_limit(16'($urandom_range(1, 24)));
    random_phase();

    // Full rate on both sides for one stretch
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    set_limit(16'hFFFF);
    random_phase();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    set_limit(16'd1);
    random_phase();
    set_limit(16'($urandom_range(0, 65535)));
    random_phase();
    set_limit(16'd5);
    random_phase();

    settle();
    repeat (12) @(posedge clk);

    $display("Run: %0d input words in %0d messages, %0d output words checked,",
             words_in, messages, words_out);
    $display("     %0d limit settings including 0 and 65535.", settings);
    if (errors == 0 && waiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
